// ===== rtl/core/hsr_pkg.sv =====
// Shared constants, types and radix table for the Halton row generator.
package hsr_pkg;

  // Default build figures
  localparam int HSR_MAX_AXES      = 45;
  localparam int HSR_INDEX_BITS    = 32;
  localparam int HSR_FRACTION_BITS = 31;

  // Word field widths
  localparam int SEQ_INDEX_W   = 32;
  localparam int AXIS_NUMBER_W = 6;
  localparam int COORD_W       = 32;
  localparam int AXIS_COUNT_W  = 6;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 6;
  localparam int RADIX_W       = 8;
  localparam int TABLE_DEPTH   = 45;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIPOLAR_MODE = 2'd1;

  // The 45 odd primes, one radix per axis
  localparam logic [RADIX_W-1:0] PRIME_RADIX [TABLE_DEPTH] = '{
    8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,  8'd23,  8'd29,
    8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,  8'd59,  8'd61,  8'd67,
    8'd71,  8'd73,  8'd79,  8'd83,  8'd89,  8'd97,  8'd101, 8'd103, 8'd107,
    8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157,
    8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199
  };

  typedef struct packed {
    logic               start;
    logic               bipolar;
    logic [RADIX_W-1:0] radix;
  } hsr_req_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] coordinate;
  } hsr_res_t;

  function automatic logic [RADIX_W-1:0] radix_of(input logic [AXIS_NUMBER_W-1:0] axis);
    logic [RADIX_W-1:0] r;
    r = PRIME_RADIX[TABLE_DEPTH-1];
    if (axis < AXIS_NUMBER_W'(TABLE_DEPTH)) begin
      r = PRIME_RADIX[axis];
    end
    return r;
  endfunction

  // floor(log2(r)): bits a quotient is guaranteed to lose per digit
  function automatic logic [2:0] radix_log2(input logic [RADIX_W-1:0] r);
    logic [2:0] l;
    l = 3'd0;
    for (int b = 1; b < RADIX_W; b++) begin
      if (r[b]) begin
        l = 3'(b);
      end
    end
    return l;
  endfunction

endpackage

// ===== rtl/core/hsr_intf.sv =====
// Valid/ready channel interfaces: index in, coordinate out, register writes.
interface hsr_in_if;
  import hsr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SEQ_INDEX_W-1:0] seq_index;
  modport source (output valid, output seq_index, input ready);
  modport sink   (input valid, input seq_index, output ready);
endinterface

interface hsr_out_if;
  import hsr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [AXIS_NUMBER_W-1:0] axis_number;
  logic [COORD_W-1:0]       coordinate;
  logic                     last_axis;
  modport source (output valid, output axis_number, output coordinate,
                  output last_axis, input ready);
  modport sink   (input valid, input axis_number, input coordinate,
                  input last_axis, output ready);
endinterface

interface hsr_cfg_if;
  import hsr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hsr_radinv.sv =====
// Bit-serial radical inverse of one index in one radix, exact floor to fixed point.
module hsr_radinv #(
  parameter int INDEX_BITS    = hsr_pkg::HSR_INDEX_BITS,
  parameter int FRACTION_BITS = hsr_pkg::HSR_FRACTION_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hsr_pkg::hsr_req_t       req_i,
  input  logic [INDEX_BITS-1:0]   index_i,
  input  logic                    res_ack_i,
  output hsr_pkg::hsr_res_t       res_o
);
  import hsr_pkg::*;

  localparam int LEN_W  = $clog2(INDEX_BITS + 1);
  localparam int DEN_W  = INDEX_BITS + RADIX_W;
  localparam int NUM_W  = DEN_W + 1;
  localparam int FCNT_W = $clog2(FRACTION_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_PREP = 3'd3;
  localparam logic [2:0] ST_FRAC = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]               st_q, st_d;
  logic [INDEX_BITS-1:0]    sh_q;
  logic [RADIX_W-1:0]       rem_q;
  logic [LEN_W-1:0]         len_q;
  logic [LEN_W-1:0]         cnt_q;
  logic [RADIX_W-1:0]       radix_q;
  logic                     bip_q;
  logic signed [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W-1:0]         frem_q;
  logic [FRACTION_BITS-1:0] fq_q;
  logic [FCNT_W-1:0]        fcnt_q;

  // digit step: remainder picks up one index bit
  logic [RADIX_W:0]   div_t;
  logic               div_ge;
  logic [RADIX_W-1:0] div_rem;

  assign div_t   = {rem_q, sh_q[INDEX_BITS-1]};
  assign div_ge  = div_t >= {1'b0, radix_q};
  assign div_rem = div_ge ? RADIX_W'(div_t - {1'b0, radix_q}) : div_t[RADIX_W-1:0];

  // digit weight, bipolar odd digits negative
  logic [RADIX_W:0]         w_mag;
  logic [NUM_W-1:0]         w_pos;
  logic [NUM_W-1:0]         w_ext;
  logic signed [NUM_W+RADIX_W:0] num_prod;
  logic [NUM_W-1:0]         num_acc;
  logic [DEN_W+RADIX_W-1:0] den_prod;

  assign w_mag    = {1'b0, rem_q} + {{RADIX_W{1'b0}}, bip_q & rem_q[0]};
  assign w_pos    = {{(NUM_W-RADIX_W-1){1'b0}}, w_mag};
  assign w_ext    = (bip_q && rem_q[0]) ? (~w_pos + 1'b1) : w_pos;
  assign num_prod = num_q * $signed({1'b0, radix_q});
  assign num_acc  = num_prod[NUM_W-1:0] + w_ext;
  assign den_prod = den_q * radix_q;

  // window of the next quotient
  logic [2:0]            fl;
  logic [LEN_W-1:0]      len_new;
  logic [LEN_W-1:0]      align;
  logic                  quot_zero;

  assign fl        = radix_log2(radix_q);
  assign len_new   = (len_q > LEN_W'(fl)) ? (len_q - LEN_W'(fl)) : '0;
  assign align     = LEN_W'(INDEX_BITS) - len_new;
  assign quot_zero = (sh_q == '0);

  // fraction step: long division of |num| by den
  logic [NUM_W-1:0] num_neg;
  logic [DEN_W-1:0] num_mag;
  logic [DEN_W:0]   f_t;
  logic             f_ge;
  logic [DEN_W-1:0] frem_next;

  assign num_neg   = ~num_q + 1'b1;
  assign num_mag   = num_q[NUM_W-1] ? num_neg[DEN_W-1:0] : num_q[DEN_W-1:0];
  assign f_t       = {frem_q, 1'b0};
  assign f_ge      = f_t >= {1'b0, den_q};
  assign frem_next = f_ge ? DEN_W'(f_t - {1'b0, den_q}) : f_t[DEN_W-1:0];

  // floor of a negative value rounds the magnitude up
  logic             neg;
  logic [COORD_W-1:0] q_adj;

  assign neg   = num_q[NUM_W-1];
  assign q_adj = COORD_W'(fq_q) + COORD_W'(neg && (frem_q != '0));

  assign res_o.valid      = (st_q == ST_DONE);
  assign res_o.coordinate = neg ? (~q_adj + 1'b1) : q_adj;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (req_i.start) begin
          st_d = (index_i == '0) ? ST_PREP : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == LEN_W'(1)) begin
          st_d = ST_ACC;
        end
      end
      ST_ACC: begin
        st_d = quot_zero ? ST_PREP : ST_DIV;
      end
      ST_PREP: begin
        st_d = ST_FRAC;
      end
      ST_FRAC: begin
        if (fcnt_q == FCNT_W'(1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ack_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        sh_q    <= index_i;
        len_q   <= LEN_W'(INDEX_BITS);
        cnt_q   <= LEN_W'(INDEX_BITS);
        rem_q   <= '0;
        radix_q <= req_i.radix;
        bip_q   <= req_i.bipolar;
        num_q   <= '0;
        den_q   <= DEN_W'(1);
      end
      ST_DIV: begin
        sh_q  <= {sh_q[INDEX_BITS-2:0], div_ge};
        rem_q <= div_rem;
        cnt_q <= cnt_q - 1'b1;
      end
      ST_ACC: begin
        num_q <= $signed(num_acc);
        den_q <= den_prod[DEN_W-1:0];
        sh_q  <= sh_q << align;
        len_q <= len_new;
        cnt_q <= len_new;
        rem_q <= '0;
      end
      ST_PREP: begin
        frem_q <= num_mag;
        fq_q   <= '0;
        fcnt_q <= FCNT_W'(FRACTION_BITS);
      end
      ST_FRAC: begin
        frem_q <= frem_next;
        fq_q   <= {fq_q[FRACTION_BITS-2:0], f_ge};
        fcnt_q <= fcnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_digit_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (rem_q < radix_q))
    else $error("digit remainder reached radix");

  a_num_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PREP) |-> (num_mag < den_q))
    else $error("numerator magnitude not below denominator");

  a_frac_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FRAC) |-> (frem_q < den_q))
    else $error("fraction remainder not below denominator");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && !res_ack_i) |=> (st_q == ST_DONE))
    else $error("result dropped before acknowledge");

endmodule

// ===== rtl/core/halton_sequence_row_top.sv =====
// Halton row generator: one index word in, one coordinate word per axis out.
// Per axis, digits come out bit-serially over a window of index bits; the window
//   starts at INDEX_BITS, shrinks by floor(log2(radix)) per digit. Index zero skips the digits.
// The first word follows the work of axis zero after the accept; output stalls add directly.
// One index at a time: the next index is taken once the last word of a row is registered.
// Reset (async, active low): axis_count = 1, bipolar_mode = 0, pipeline empty.
module halton_sequence_row_top #(
  parameter int MAX_AXES      = hsr_pkg::HSR_MAX_AXES,
  parameter int INDEX_BITS    = hsr_pkg::HSR_INDEX_BITS,
  parameter int FRACTION_BITS = hsr_pkg::HSR_FRACTION_BITS
) (
  input logic       clk_i,
  input logic       rst_ni,
  hsr_cfg_if.sink   cfg_i,
  hsr_in_if.sink    in_i,
  hsr_out_if.source out_o
);
  import hsr_pkg::*;

  localparam int AXIS_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int CNT_W  = $clog2(MAX_AXES + 1);

  // Configuration registers, always writable
  logic [AXIS_COUNT_W-1:0] axis_count_q;
  logic                    bipolar_q;

  // Per-index sequencing
  logic                  busy_q;
  logic                  start_q;
  logic [AXIS_W-1:0]     axis_q;
  logic [CNT_W-1:0]      n_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  bip_run_q;

  // Output word register
  logic                     out_valid_q;
  logic [AXIS_NUMBER_W-1:0] out_axis_q;
  logic [COORD_W-1:0]       out_coord_q;
  logic                     out_last_q;

  logic       in_acc;
  logic       out_free;
  logic       res_take;
  logic       last;
  logic [CNT_W-1:0] axis_next;
  logic [CNT_W-1:0] n_sat;
  hsr_req_t   req;
  hsr_res_t   res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !busy_q;
  assign in_acc      = in_i.valid && !busy_q;

  // Output register frees when empty or drained this cycle
  assign out_free = !out_valid_q || out_o.ready;
  assign res_take = res.valid && out_free;

  assign axis_next = CNT_W'(axis_q) + 1'b1;
  assign last      = (axis_next == n_q);

  // Axis count of zero means one; beyond the table it saturates
  always_comb begin
    if (axis_count_q == '0) begin
      n_sat = CNT_W'(1);
    end else if (axis_count_q > AXIS_COUNT_W'(MAX_AXES)) begin
      n_sat = CNT_W'(MAX_AXES);
    end else begin
      n_sat = CNT_W'(axis_count_q);
    end
  end

  assign req.start   = start_q;
  assign req.bipolar = bip_run_q;
  assign req.radix   = radix_of(AXIS_NUMBER_W'(axis_q));

  hsr_radinv #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_radinv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .index_i   (idx_q),
    .res_ack_i (out_free),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= AXIS_COUNT_W'(1);
      bipolar_q    <= 1'b0;
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      axis_q       <= '0;
      n_q          <= CNT_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_AXIS_COUNT: begin
            axis_count_q <= cfg_i.data[AXIS_COUNT_W-1:0];
          end
          CFG_BIPOLAR_MODE: begin
            bipolar_q <= cfg_i.data[0];
          end
          default: begin
          end
        endcase
      end

      start_q <= 1'b0;
      if (in_acc) begin
        busy_q  <= 1'b1;
        axis_q  <= '0;
        n_q     <= n_sat;
        start_q <= 1'b1;
      end else if (res_take) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          axis_q  <= axis_q + 1'b1;
          start_q <= 1'b1;
        end
      end

      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: index and mode snapshot at accept, result word at hand-over
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q     <= in_i.seq_index[INDEX_BITS-1:0];
      bip_run_q <= bipolar_q;
    end
    if (res_take) begin
      out_axis_q  <= AXIS_NUMBER_W'(axis_q);
      out_coord_q <= res.coordinate;
      out_last_q  <= last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.axis_number = out_axis_q;
  assign out_o.coordinate  = out_coord_q;
  assign out_o.last_axis   = out_last_q;

  a_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> busy_q)
    else $error("axis start issued while idle");

  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> busy_q)
    else $error("coordinate reported while idle");

  a_axis_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (CNT_W'(axis_q) < n_q))
    else $error("axis counter beyond axis count");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (start_q && axis_q == '0))
    else $error("accepted index did not start axis zero");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the Halton row generator: predicted coordinates vs DUT words.
`timescale 1ns / 1ps

module tb;
  import hsr_pkg::*;

  // Quiet cycles allowed with no word moving on any channel. The slowest axis is
  // radix 3, with up to 21 digits, and stalls add to its time.
  localparam int IDLE_LIMIT    = 5000;
  // Settling time after the last expected word, about one slow axis
  localparam int SETTLE_CYCLES = 600;
  // Register index outside the map: the block must ignore writes to it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct {
    logic [SEQ_INDEX_W-1:0] seq;
    bit                     drain_first;  // hold back until every coordinate is in
  } index_job_t;

  typedef struct {
    logic [AXIS_NUMBER_W-1:0] axis;
    logic [COORD_W-1:0]       coord;
    logic                     last;
  } coord_word_t;

  logic clk_i;
  logic rst_ni;

  hsr_cfg_if cfg_if ();
  hsr_in_if  in_if ();
  hsr_out_if out_if ();

  halton_sequence_row_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  index_job_t  index_backlog[$];  // index words still to be offered
  coord_word_t coords_due[$];     // predicted coordinate words, oldest first

  // Shadow of the register file, as the block should hold it
  logic [AXIS_COUNT_W-1:0] axis_count_sh;
  logic                    bipolar_sh;

  int mismatch_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  index_job_t  next_job;
  coord_word_t head;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Radical inverse of seq in the given radix, floored to signed Q1.31.
  // Exact rational arithmetic: numerator and denominator stay below 2^40.
  function automatic logic [COORD_W-1:0] mirrored_coordinate(
      input logic [SEQ_INDEX_W-1:0] seq, input int unsigned radix, input bit bip);
    longint          num;
    longint          digit;
    longint          weight;
    longint unsigned den;
    longint unsigned rest;
    longint unsigned mag;
    longint unsigned rem;
    longint unsigned quo;
    int              bitpos;
    num  = 0;
    den  = 1;
    rest = seq;
    while (rest != 0) begin
      digit = rest % radix;
      rest  = rest / radix;
      // bipolar digits map 0,1,2,3,4,... onto 0,-2,+2,-4,+4,...
      if (bip) begin
        weight = ((digit + 1) / 2) * 2;
        if (digit % 2 != 0) weight = -weight;
      end else begin
        weight = digit;
      end
      num = num * longint'(radix) + weight;
      den = den * radix;
    end
    mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
    rem = mag;
    quo = 0;
    for (bitpos = 0; bitpos < HSR_FRACTION_BITS; bitpos++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 1;
      end
    end
    // negative values round toward minus infinity
    if (num < 0) begin
      if (rem != 0) quo = quo + 1;
      return COORD_W'(0 - quo);
    end
    return COORD_W'(quo);
  endfunction

  // One coordinate word per axis, axis count clamped to 1..45
  function automatic void predict_row(input logic [SEQ_INDEX_W-1:0] seq);
    int unsigned n;
    int unsigned k;
    coord_word_t w;
    n = axis_count_sh;
    if (n == 0) n = 1;
    if (n > HSR_MAX_AXES) n = HSR_MAX_AXES;
    for (k = 0; k < n; k++) begin
      w.axis  = AXIS_NUMBER_W'(k);
      w.coord = mirrored_coordinate(seq, PRIME_RADIX[k], bipolar_sh);
      w.last  = (k + 1 == n);
      coords_due.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Driver: a word is taken at an edge with valid and ready high; the next one
  // goes on the bus at that same edge unless the sender idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_row(in_if.seq_index);
      end
      if (!in_if.valid || in_if.ready) begin
        if (index_backlog.size() != 0 &&
            !(index_backlog[0].drain_first && coords_due.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct) begin
          next_job = index_backlog.pop_front();
          in_if.valid     <= 1'b1;
          in_if.seq_index <= next_job.seq;
        end else begin
          in_if.valid     <= 1'b0;
          in_if.seq_index <= $urandom;  // junk while idle
        end
      end
    end
  end

  // Monitor: every coordinate word is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (coords_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word axis %0d coordinate %h",
                                    out_if.axis_number, out_if.coordinate));
        end else begin
          head = coords_due.pop_front();
          if (out_if.axis_number !== head.axis)
            report_mismatch($sformatf("axis_number %0d, want %0d",
                                      out_if.axis_number, head.axis));
          if (out_if.coordinate !== head.coord)
            report_mismatch($sformatf("axis %0d coordinate %h, want %h",
                                      head.axis, out_if.coordinate, head.coord));
          if (out_if.last_axis !== head.last)
            report_mismatch($sformatf("axis %0d last_axis %b, want %b",
                                      head.axis, out_if.last_axis, head.last));
        end
      end
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles with no word moving anywhere
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_index(input logic [SEQ_INDEX_W-1:0] seq, input bit drain_first = 1'b0);
    index_job_t job;
    job.seq         = seq;
    job.drain_first = drain_first;
    index_backlog.push_back(job);
  endtask

  // Mostly full-width indexes; some with few digits or near the top
  function automatic logic [SEQ_INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0: return SEQ_INDEX_W'($urandom_range(0, 40));
      1: return 32'hFFFF_FFFF - SEQ_INDEX_W'($urandom_range(0, 40));
      2: return SEQ_INDEX_W'($urandom) >> $urandom_range(1, 31);
      default: return SEQ_INDEX_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int n, input int drain_at = -1);
    int i;
    for (i = 0; i < n; i++) begin
      push_index(pick_index(), i == drain_at);
    end
  endtask

  // Runs from a rising edge to the edge where nothing is pending or in flight
  task automatic wait_drained();
    while (index_backlog.size() != 0 || in_if.valid || coords_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Leaves valid high: the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_AXIS_COUNT:   axis_count_sh = data;
      CFG_BIPOLAR_MODE: bipolar_sh    = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int count_val, input bit bip_val, input int snd_pct,
                               input int rcv_pct, input bit poke_unmapped = 1'b0);
    logic [CFG_DATA_W-1:0] bip_data;
    wait_drained();
    if (poke_unmapped) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    write_reg(CFG_AXIS_COUNT, CFG_DATA_W'(count_val));
    // upper data bits are don't-care for the mode register
    bip_data    = CFG_DATA_W'($urandom);
    bip_data[0] = bip_val;
    write_reg(CFG_BIPOLAR_MODE, bip_data);
    cfg_if.valid       <= 1'b0;
    sender_idle_pct    = snd_pct;
    receiver_stall_pct = rcv_pct;
  endtask

  initial begin
    mismatch_count     = 0;
    quiet_cycles       = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    axis_count_sh      = AXIS_COUNT_W'(1);
    bipolar_sh         = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_AXIS_COUNT;
    cfg_if.data        = '0;
    in_if.valid        = 1'b0;
    in_if.seq_index    = '0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one axis, unipolar. Zero, extremes and digit patterns.
    push_index(32'h0000_0000);
    push_index(32'h0000_0001);
    push_index(32'h0000_0002);
    push_index(32'h0000_0003);
    push_index(32'hFFFF_FFFF);
    push_index(32'h8000_0000);
    push_index(32'h5555_5555);
    push_index(32'hAAAA_AAAA);

    // Axis count zero acts as one; bipolar digits give both signs.
    // A write to an unmapped register must leave the setting alone.
    apply_setting(0, 1'b1, 0, 0, 1'b1);
    push_index(32'h0000_0001);
    push_index(32'h0000_0002);
    push_index(32'h0000_0003);
    push_index(32'h0000_0000);
    push_index(32'hFFFF_FFFF);
    push_index(32'h7FFF_FFFF);

    // Oversized axis counts saturate to the full 45-axis row
    apply_setting(63, 1'b0, 0, 0);
    push_index(32'hFFFF_FFFF);
    push_index(32'h0000_0001);
    apply_setting(46, 1'b1, 0, 0);
    push_index(32'hFFFF_FFFF);
    push_index(32'h0000_0005);

    // Full row, exact count; only a handful since each index is slow
    apply_setting(HSR_MAX_AXES, 1'b0, 0, 0);
    push_index(32'h3B9A_CA00);
    queue_random(3);

    // Random part, one idling pattern per setting
    apply_setting(1, 1'b1, 74, 0);
    queue_random(40);
    apply_setting(3, 1'b0, 0, 74);
    queue_random(40, 20);
    apply_setting($urandom_range(2, 8), 1'($urandom_range(0, 1)), 7, 7);
    queue_random(40);
    apply_setting(2, 1'b1, 0, 0);
    queue_random(30, 10);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && coords_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== halton_sequence_row_top.f =====
rtl/core/hsr_pkg.sv
rtl/core/hsr_intf.sv
rtl/core/hsr_radinv.sv
rtl/core/halton_sequence_row_top.sv
tb/tb.sv
